>>> src/gic_pkg.sv
// ----------------------------------------------------------------------------
// gic_pkg: shared types and constants of the 4D grid index converter
// Widths, register indexes and the beat that moves along the cell chain.
// ----------------------------------------------------------------------------
package gic_pkg;

  localparam int unsigned MAX_SIZE = 1024;
  localparam int unsigned SizeW    = 11;
  localparam int unsigned CoordW   = 10;
  localparam int unsigned LinW     = 40;
  localparam int unsigned CfgIdxW  = 2;
  // one cell per quotient bit, three divisions
  localparam int unsigned NumCells = 3 * LinW;

  localparam logic [CfgIdxW-1:0] CfgSizeX = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgSizeY = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgSizeZ = 2'd2;
  localparam logic [CfgIdxW-1:0] CfgSizeT = 2'd3;

  localparam logic ReqFwd = 1'b0;
  localparam logic ReqInv = 1'b1;

  typedef struct packed {
    logic              vld;
    logic              inv;
    logic              ok_f;
    logic [LinW-1:0]   lin_f;
    logic [LinW-1:0]   n;
    logic [SizeW-1:0]  r;
    logic [CoordW-1:0] cx;
    logic [CoordW-1:0] cy;
  } beat_t;

endpackage

>>> src/grid_index_converter_4d.sv
// ----------------------------------------------------------------------------
// grid_index_converter_4d: row-major 4D coordinate / linear index converter
// Forward beats map (x, y, z, t) to an index; inverse beats split an index.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel in_valid_i / in_stall_o carries req_type and both operand
//   sets; output channel out_valid_o / out_stall_i returns one result beat
//   per request, in order. A beat moves when valid is high and stall low.
//   Sizes are written through cfg_we_i / cfg_idx_i / cfg_data_i while idle;
//   0 reads as 1 and values above MAX_SIZE read as MAX_SIZE.
// Pipeline:
//   three multiply-add stages, a chain of 120 division cells (one
//   quotient bit per cell, 40 bits per divisor for x, y and z) and an
//   output register. One request is taken every cycle unless stalled.
// Stall and reset:
//   a stalled output beat freezes the whole pipeline and raises in_stall_o
//   in the same cycle. Reset empties the pipeline and sets all sizes to 1.
// ----------------------------------------------------------------------------
module grid_index_converter_4d (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [gic_pkg::CfgIdxW-1:0]         cfg_idx_i,
  input  logic [gic_pkg::SizeW-1:0]           cfg_data_i,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic                                req_type_i,
  input  logic [gic_pkg::CoordW-1:0]          coord_x_i,
  input  logic [gic_pkg::CoordW-1:0]          coord_y_i,
  input  logic [gic_pkg::CoordW-1:0]          coord_z_i,
  input  logic [gic_pkg::CoordW-1:0]          coord_t_i,
  input  logic [gic_pkg::LinW-1:0]            linear_in_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic [gic_pkg::LinW-1:0]            linear_out_o,
  output logic [gic_pkg::CoordW-1:0]          out_x_o,
  output logic [gic_pkg::CoordW-1:0]          out_y_o,
  output logic [gic_pkg::CoordW-1:0]          out_z_o,
  output logic [gic_pkg::CoordW-1:0]          out_t_o,
  output logic                                in_range_o
);

  logic [gic_pkg::SizeW-1:0] sx_q, sy_q, sz_q, st_q, eff;
  logic                      en;
  gic_pkg::beat_t            chain [gic_pkg::NumCells+1];
  gic_pkg::beat_t            last;
  logic                      ok_inv;
  logic                      vld_q, ok_q;
  logic [gic_pkg::LinW-1:0]  lin_q;
  logic [gic_pkg::CoordW-1:0] ox_q, oy_q, oz_q, ot_q;

  always_comb begin
    if (cfg_data_i == '0) begin
      eff = gic_pkg::SizeW'(1);
    end else if (32'(cfg_data_i) > gic_pkg::MAX_SIZE) begin
      eff = gic_pkg::SizeW'(gic_pkg::MAX_SIZE);
    end else begin
      eff = cfg_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sx_q <= gic_pkg::SizeW'(1);
      sy_q <= gic_pkg::SizeW'(1);
      sz_q <= gic_pkg::SizeW'(1);
      st_q <= gic_pkg::SizeW'(1);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        gic_pkg::CfgSizeX: sx_q <= eff;
        gic_pkg::CfgSizeY: sy_q <= eff;
        gic_pkg::CfgSizeZ: sz_q <= eff;
        gic_pkg::CfgSizeT: st_q <= eff;
        default: ;
      endcase
    end
  end

  // the whole pipeline advances unless the output beat is held
  assign en         = !(vld_q && out_stall_i);
  assign in_stall_o = !en;

  gic_fwd u_fwd (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .en_i       (en),
    .vld_i      (in_valid_i),
    .req_type_i (req_type_i),
    .coord_x_i  (coord_x_i),
    .coord_y_i  (coord_y_i),
    .coord_z_i  (coord_z_i),
    .coord_t_i  (coord_t_i),
    .linear_in_i(linear_in_i),
    .sx_i       (sx_q),
    .sy_i       (sy_q),
    .sz_i       (sz_q),
    .st_i       (st_q),
    .beat_o     (chain[0])
  );

  for (genvar g = 0; g < gic_pkg::NumCells; g++) begin : g_cell
    localparam int unsigned Div = g / gic_pkg::LinW;
    gic_cell #(.STEP(g)) u_cell (
      .clk_i (clk_i),
      .rst_ni(rst_ni),
      .en_i  (en),
      .div_i ((Div == 0) ? sx_q : ((Div == 1) ? sy_q : sz_q)),
      .beat_i(chain[g]),
      .beat_o(chain[g+1])
    );
  end

  assign last   = chain[gic_pkg::NumCells];
  assign ok_inv = last.n < gic_pkg::LinW'(st_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (en) begin
      vld_q <= last.vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      if (last.inv == gic_pkg::ReqInv) begin
        ok_q  <= ok_inv;
        lin_q <= '0;
        ox_q  <= ok_inv ? last.cx : '0;
        oy_q  <= ok_inv ? last.cy : '0;
        oz_q  <= ok_inv ? last.r[gic_pkg::CoordW-1:0] : '0;
        ot_q  <= ok_inv ? last.n[gic_pkg::CoordW-1:0] : '0;
      end else begin
        ok_q  <= last.ok_f;
        lin_q <= last.ok_f ? last.lin_f : '0;
        ox_q  <= '0;
        oy_q  <= '0;
        oz_q  <= '0;
        ot_q  <= '0;
      end
    end
  end

  assign out_valid_o  = vld_q;
  assign linear_out_o = lin_q;
  assign out_x_o      = ox_q;
  assign out_y_o      = oy_q;
  assign out_z_o      = oz_q;
  assign out_t_o      = ot_q;
  assign in_range_o   = ok_q;

  a_oor_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !in_range_o |-> linear_out_o == '0 && out_x_o == '0 &&
      out_y_o == '0 && out_z_o == '0 && out_t_o == '0)
    else $error("out-of-range beat carries nonzero fields");

  a_fwd_no_coords: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && linear_out_o != '0 |-> out_x_o == '0 && out_y_o == '0 &&
      out_z_o == '0 && out_t_o == '0)
    else $error("forward beat carries coordinates");

  a_stall_freeze: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |-> in_stall_o)
    else $error("input taken while output beat is held");

endmodule

>>> src/gic_fwd.sv
// ----------------------------------------------------------------------------
// gic_fwd: forward index multiply-add pipeline
// Three registered multiply-add stages; inverse beats ride along unchanged.
// ----------------------------------------------------------------------------
module gic_fwd (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              en_i,
  input  logic                              vld_i,
  input  logic                              req_type_i,
  input  logic [gic_pkg::CoordW-1:0]        coord_x_i,
  input  logic [gic_pkg::CoordW-1:0]        coord_y_i,
  input  logic [gic_pkg::CoordW-1:0]        coord_z_i,
  input  logic [gic_pkg::CoordW-1:0]        coord_t_i,
  input  logic [gic_pkg::LinW-1:0]          linear_in_i,
  input  logic [gic_pkg::SizeW-1:0]         sx_i,
  input  logic [gic_pkg::SizeW-1:0]         sy_i,
  input  logic [gic_pkg::SizeW-1:0]         sz_i,
  input  logic [gic_pkg::SizeW-1:0]         st_i,
  output gic_pkg::beat_t                    beat_o
);

  localparam int unsigned A1W = gic_pkg::CoordW + gic_pkg::SizeW;
  localparam int unsigned A2W = A1W + gic_pkg::SizeW - 1;

  logic                       v1_q, v2_q, i1_q, i2_q, ok1_q, ok2_q;
  logic [A1W-1:0]             a1_q;
  logic [A2W-1:0]             a2_q;
  logic [gic_pkg::CoordW-1:0] x1_q, y1_q, x2_q;
  logic [gic_pkg::LinW-1:0]   l1_q, l2_q;
  logic                       ok_d;
  gic_pkg::beat_t             beat_q;

  assign ok_d = ({1'b0, coord_x_i} < sx_i) && ({1'b0, coord_y_i} < sy_i) &&
                ({1'b0, coord_z_i} < sz_i) && ({1'b0, coord_t_i} < st_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q   <= 1'b0;
      v2_q   <= 1'b0;
      beat_q <= '0;
    end else if (en_i) begin
      v1_q       <= vld_i;
      v2_q       <= v1_q;
      beat_q.vld <= v2_q;
      beat_q.inv <= i2_q;
      beat_q.ok_f  <= ok2_q;
      beat_q.lin_f <= gic_pkg::LinW'(a2_q * sx_i) + gic_pkg::LinW'(x2_q);
      beat_q.n   <= (i2_q == gic_pkg::ReqInv) ? l2_q : '0;
      beat_q.r   <= '0;
      beat_q.cx  <= '0;
      beat_q.cy  <= '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      i1_q  <= req_type_i;
      ok1_q <= ok_d;
      a1_q  <= A1W'(coord_t_i * sz_i) + A1W'(coord_z_i);
      x1_q  <= coord_x_i;
      y1_q  <= coord_y_i;
      l1_q  <= linear_in_i;
      i2_q  <= i1_q;
      ok2_q <= ok1_q;
      a2_q  <= A2W'(a1_q * sy_i) + A2W'(y1_q);
      x2_q  <= x1_q;
      l2_q  <= l1_q;
    end
  end

  assign beat_o = beat_q;

endmodule

>>> src/gic_cell.sv
// ----------------------------------------------------------------------------
// gic_cell: one restoring division step
// Brings in one dividend bit, yields one quotient bit; on the first step of
// a new division it files the previous remainder as a coordinate.
// ----------------------------------------------------------------------------
module gic_cell #(
  parameter int unsigned STEP = 0
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      en_i,
  input  logic [gic_pkg::SizeW-1:0] div_i,
  input  gic_pkg::beat_t            beat_i,
  output gic_pkg::beat_t            beat_o
);

  localparam int unsigned Slot  = STEP / gic_pkg::LinW;
  localparam bit          Start = (STEP % gic_pkg::LinW == 0) && (STEP != 0);

  gic_pkg::beat_t           b, beat_q;
  logic [gic_pkg::SizeW:0]  rr;
  logic                     qb;

  always_comb begin
    b = beat_i;
    if (Start) begin
      if (Slot == 1) b.cx = beat_i.r[gic_pkg::CoordW-1:0];
      else           b.cy = beat_i.r[gic_pkg::CoordW-1:0];
      b.r = '0;
    end
    rr = {b.r, b.n[gic_pkg::LinW-1]};
    qb = (rr >= {1'b0, div_i});
    b.r = qb ? gic_pkg::SizeW'(rr - {1'b0, div_i}) : rr[gic_pkg::SizeW-1:0];
    b.n = {b.n[gic_pkg::LinW-2:0], qb};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      beat_q <= '0;
    end else if (en_i) begin
      beat_q <= b;
    end
  end

  assign beat_o = beat_q;

endmodule

>>> test/grid_index_converter_4d_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// grid_index_converter_4d_test: self-checking bench for the 4D index converter
// Drives forward and inverse requests under many grid sizes, including sizes
// of zero and beyond the maximum, and compares every output beat against a
// behavioral model of the row-major mapping, with random idling and stalls.
// ----------------------------------------------------------------------------
module grid_index_converter_4d_test;

  typedef struct packed {
    logic [gic_pkg::LinW-1:0]   lin;
    logic [gic_pkg::CoordW-1:0] x;
    logic [gic_pkg::CoordW-1:0] y;
    logic [gic_pkg::CoordW-1:0] z;
    logic [gic_pkg::CoordW-1:0] t;
    logic                       ok;
  } grid_result_t;

  logic                        clk_i = 1'b0;
  logic                        rst_ni = 1'b0;
  logic                        cfg_we_i = 1'b0;
  logic [gic_pkg::CfgIdxW-1:0] cfg_idx_i = '0;
  logic [gic_pkg::SizeW-1:0]   cfg_data_i = '0;
  logic                        in_valid_i = 1'b0;
  logic                        in_stall_o;
  logic                        req_type_i = gic_pkg::ReqFwd;
  logic [gic_pkg::CoordW-1:0]  coord_x_i = '0;
  logic [gic_pkg::CoordW-1:0]  coord_y_i = '0;
  logic [gic_pkg::CoordW-1:0]  coord_z_i = '0;
  logic [gic_pkg::CoordW-1:0]  coord_t_i = '0;
  logic [gic_pkg::LinW-1:0]    linear_in_i = '0;
  logic                        out_valid_o;
  logic                        out_stall_i = 1'b0;
  logic [gic_pkg::LinW-1:0]    linear_out_o;
  logic [gic_pkg::CoordW-1:0]  out_x_o, out_y_o, out_z_o, out_t_o;
  logic                        in_range_o;

  grid_index_converter_4d uut (.*);

  always #4 clk_i = ~clk_i;

  logic [gic_pkg::SizeW-1:0] grid_size [4];
  grid_result_t     pending_results [$];
  int gap_pct = 0;
  int stall_pct = 0;
  int hold_request = 0;
  int hold_left = 0;
  int mismatches = 0;
  int results_seen = 0;
  int fwd_sent = 0;
  int inv_sent = 0;
  int in_range_seen = 0;

  function automatic logic [63:0] eff_size(logic [gic_pkg::SizeW-1:0] v);
    if (v == 0) return 64'd1;
    if (v > gic_pkg::MAX_SIZE) return 64'(gic_pkg::MAX_SIZE);
    return 64'(v);
  endfunction

  function automatic logic [63:0] grid_points();
    return eff_size(grid_size[0]) * eff_size(grid_size[1]) *
           eff_size(grid_size[2]) * eff_size(grid_size[3]);
  endfunction

  function automatic grid_result_t convert_index(logic rt,
      logic [gic_pkg::CoordW-1:0] x, logic [gic_pkg::CoordW-1:0] y,
      logic [gic_pkg::CoordW-1:0] z, logic [gic_pkg::CoordW-1:0] t,
      logic [gic_pkg::LinW-1:0] lin);
    grid_result_t r;
    logic [63:0] sx, sy, sz, st, pxy, pxyz, q, rest;
    sx = eff_size(grid_size[0]);
    sy = eff_size(grid_size[1]);
    sz = eff_size(grid_size[2]);
    st = eff_size(grid_size[3]);
    r = '0;
    if (rt == gic_pkg::ReqFwd) begin
      if (x < sx && y < sy && z < sz && t < st) begin
        r.lin = gic_pkg::LinW'(((64'(t) * sz + z) * sy + y) * sx + x);
        r.ok = 1'b1;
      end
    end else begin
      pxy = sx * sy;
      pxyz = pxy * sz;
      q = 64'(lin) / pxyz;
      if (q < st) begin
        rest = 64'(lin) % pxyz;
        r.t = gic_pkg::CoordW'(q);
        r.z = gic_pkg::CoordW'(rest / pxy);
        rest = rest % pxy;
        r.y = gic_pkg::CoordW'(rest / sx);
        r.x = gic_pkg::CoordW'(rest % sx);
        r.ok = 1'b1;
      end
    end
    return r;
  endfunction

  // receiver: random stalls, or a long hold-off when asked
  always @(posedge clk_i) begin
    if (hold_request > 0) begin
      hold_left = hold_request;
      hold_request = 0;
    end
    if (hold_left > 0) begin
      hold_left = hold_left - 1;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(0, 99) < stall_pct);
    end
  end

  always @(posedge clk_i) begin
    grid_result_t got, want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got = '{linear_out_o, out_x_o, out_y_o, out_z_o, out_t_o, in_range_o};
      results_seen++;
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result beat: %p", got);
      end else begin
        want = pending_results.pop_front();
        if (got.lin !== want.lin || got.x !== want.x || got.y !== want.y ||
            got.z !== want.z || got.t !== want.t || got.ok !== want.ok) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("mismatch at %0t: expected lin=%0d xyzt=%0d,%0d,%0d,%0d ok=%0b",
                     $realtime, want.lin, want.x, want.y, want.z, want.t, want.ok);
            $display("  got lin=%0d xyzt=%0d,%0d,%0d,%0d ok=%0b",
                     got.lin, got.x, got.y, got.z, got.t, got.ok);
          end
        end
        if (want.ok) in_range_seen++;
      end
    end
  end

  task automatic send_req(logic rt, logic [gic_pkg::CoordW-1:0] x,
      logic [gic_pkg::CoordW-1:0] y, logic [gic_pkg::CoordW-1:0] z,
      logic [gic_pkg::CoordW-1:0] t, logic [gic_pkg::LinW-1:0] lin);
    if ($urandom_range(0, 99) < gap_pct) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    req_type_i  <= rt;
    coord_x_i   <= x;
    coord_y_i   <= y;
    coord_z_i   <= z;
    coord_t_i   <= t;
    linear_in_i <= lin;
    do @(posedge clk_i); while (in_stall_o);
    pending_results.push_back(convert_index(rt, x, y, z, t, lin));
    if (rt == gic_pkg::ReqFwd) fwd_sent++; else inv_sent++;
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (130) @(posedge clk_i);
  endtask

  task automatic set_sizes(logic [gic_pkg::SizeW-1:0] sx, logic [gic_pkg::SizeW-1:0] sy,
      logic [gic_pkg::SizeW-1:0] sz, logic [gic_pkg::SizeW-1:0] st);
    logic [gic_pkg::SizeW-1:0] vals [4];
    vals = '{sx, sy, sz, st};
    wait_drained();
    for (int i = 0; i < 4; i++) begin
      cfg_we_i   <= 1'b1;
      cfg_idx_i  <= gic_pkg::CfgIdxW'(i);
      cfg_data_i <= vals[i];
      @(posedge clk_i);
      grid_size[i] = vals[i];
    end
    cfg_we_i <= 1'b0;
  endtask

  function automatic logic [gic_pkg::CoordW-1:0] pick_coord(int axis);
    if ($urandom_range(0, 9) < 8)
      return gic_pkg::CoordW'($urandom_range(0, int'(eff_size(grid_size[axis])) - 1));
    return gic_pkg::CoordW'($urandom);
  endfunction

  task automatic send_random();
    logic [63:0] pts;
    logic [gic_pkg::LinW-1:0] lin;
    pts = grid_points();
    if ($urandom_range(0, 9) < 5) begin
      send_req(gic_pkg::ReqFwd, pick_coord(0), pick_coord(1), pick_coord(2),
               pick_coord(3), gic_pkg::LinW'({$urandom, $urandom}));
    end else begin
      case ($urandom_range(0, 9))
        0: lin = gic_pkg::LinW'({$urandom, $urandom});
        1: lin = gic_pkg::LinW'(pts - 1);
        2: lin = gic_pkg::LinW'(pts);
        default: lin = gic_pkg::LinW'({$urandom, $urandom} % pts);
      endcase
      send_req(gic_pkg::ReqInv, gic_pkg::CoordW'($urandom), gic_pkg::CoordW'($urandom),
               gic_pkg::CoordW'($urandom), gic_pkg::CoordW'($urandom), lin);
    end
  endtask

  function automatic logic [gic_pkg::SizeW-1:0] pick_size();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return gic_pkg::SizeW'(1);
      2: return gic_pkg::SizeW'($urandom_range(2, 8));
      3: return gic_pkg::SizeW'($urandom_range(9, 1024));
      4: return gic_pkg::SizeW'($urandom_range(1025, 2047));
      default: return gic_pkg::SizeW'(gic_pkg::MAX_SIZE);
    endcase
  endfunction

  task automatic test_directed();
    set_sizes(11'd3, 11'd5, 11'd7, 11'd2);
    send_req(gic_pkg::ReqFwd, 0, 0, 0, 0, 0);
    send_req(gic_pkg::ReqFwd, 2, 4, 6, 1, 0);
    send_req(gic_pkg::ReqFwd, 3, 0, 0, 0, 0);
    send_req(gic_pkg::ReqFwd, 0, 5, 0, 0, 0);
    send_req(gic_pkg::ReqFwd, 0, 0, 7, 0, 0);
    send_req(gic_pkg::ReqFwd, 0, 0, 0, 2, 0);
    send_req(gic_pkg::ReqInv, 0, 0, 0, 0, 40'd0);
    send_req(gic_pkg::ReqInv, 0, 0, 0, 0, 40'd209);
    send_req(gic_pkg::ReqInv, 0, 0, 0, 0, 40'd210);
    send_req(gic_pkg::ReqInv, 0, 0, 0, 0, '1);
    set_sizes(11'd1024, 11'd1024, 11'd1024, 11'd1024);
    send_req(gic_pkg::ReqFwd, '1, '1, '1, '1, '1);
    send_req(gic_pkg::ReqFwd, 0, 0, 0, 0, '0);
    send_req(gic_pkg::ReqInv, 0, 0, 0, 0, '1);
    send_req(gic_pkg::ReqInv, 0, 0, 0, 0, 40'h55_5555_5555);
    send_req(gic_pkg::ReqInv, '1, '1, '1, '1, 40'haa_aaaa_aaaa);
  endtask

  task automatic test_size_clamp();
    // zero reads as one, so only the origin is in range
    set_sizes(11'd0, 11'd0, 11'd0, 11'd0);
    send_req(gic_pkg::ReqFwd, 0, 0, 0, 0, 0);
    send_req(gic_pkg::ReqFwd, 1, 0, 0, 0, 0);
    send_req(gic_pkg::ReqInv, 0, 0, 0, 0, 40'd0);
    send_req(gic_pkg::ReqInv, 0, 0, 0, 0, 40'd1);
    // oversize reads as the maximum
    set_sizes(11'd2047, 11'd2047, 11'd2047, 11'd2047);
    send_req(gic_pkg::ReqFwd, '1, '1, '1, '1, 0);
    send_req(gic_pkg::ReqInv, 0, 0, 0, 0, '1);
    set_sizes(11'd1025, 11'd1, 11'd1024, 11'd0);
    send_req(gic_pkg::ReqFwd, 1023, 0, 1023, 0, 0);
    send_req(gic_pkg::ReqInv, 0, 0, 0, 0, 40'd1048575);
    send_req(gic_pkg::ReqInv, 0, 0, 0, 0, 40'd1048576);
  endtask

  task automatic test_random_phases();
    for (int ph = 0; ph < 16; ph++) begin
      case (ph % 4)
        0: begin gap_pct = 0;  stall_pct = 0;  end
        1: begin gap_pct = 62; stall_pct = 0;  end
        2: begin gap_pct = 0;  stall_pct = 62; end
        default: begin gap_pct = 26; stall_pct = 26; end
      endcase
      set_sizes(pick_size(), pick_size(), pick_size(), pick_size());
      repeat (100) send_random();
    end
  endtask

  task automatic test_backpressure();
    gap_pct = 0;
    stall_pct = 0;
    set_sizes(11'd17, 11'd9, 11'd33, 11'd5);
    hold_request = 400;
    repeat (300) send_random();
    // sender stops until everything is back
    wait_drained();
    repeat (50) send_random();
  endtask

  initial begin
    grid_size = '{default: gic_pkg::SizeW'(1)};
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_size_clamp();
    test_random_phases();
    test_backpressure();
    wait_drained();
    $display("ran %0d forward and %0d inverse requests, %0d results, %0d in range",
             fwd_sent, inv_sent, results_seen, in_range_seen);
    $display("mismatches: %0d", mismatches);
    if (mismatches == 0 && pending_results.size() == 0)
      $display("[grid_index_converter_4d] OK");
    else
      $display("[grid_index_converter_4d] ERROR");
    $finish;
  end

  initial begin
    #5ms;
    $display("timeout with %0d results outstanding", pending_results.size());
    $display("[grid_index_converter_4d] ERROR");
    $finish;
  end

endmodule

>>> filelist.f
src/gic_pkg.sv
src/gic_fwd.sv
src/gic_cell.sv
src/grid_index_converter_4d.sv
test/grid_index_converter_4d_test.sv
